>>> sv/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types, status codes and the firing order for the timer queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam logic [1:0] FN_ADD   = 2'd0;
    localparam logic [1:0] FN_DEL   = 2'd1;
    localparam logic [1:0] FN_CHECK = 2'd2;
    localparam logic [1:0] FN_NONE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_PENDING  = 3'd5;

    localparam logic [9:0] US_PER_MS = 10'd1000;

    typedef struct packed {
        logic [7:0]  handle;
        logic [62:0] t_begin;
        logic [63:0] t_expire;
    } slot_t;

    // true when (exp_a, beg_a) fires before (exp_b, beg_b)
    function automatic logic fires_before(input logic [63:0] exp_a,
                                          input logic [62:0] beg_a,
                                          input logic [63:0] exp_b,
                                          input logic [62:0] beg_b);
        logic r;
        if (exp_a != exp_b)
            r = exp_a < exp_b;
        else
            r = beg_a > beg_b;
        return r;
    endfunction

endpackage

>>> sv/tmq_slot_mem.sv
// ----------------------------------------------------------------------------
// tmq_slot_mem
// Slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmq_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  tmq_pkg::slot_t wdata,
    input  logic [AW-1:0]  raddr,
    output tmq_pkg::slot_t rdata
);
    import tmq_pkg::*;

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> sv/timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Bounded timer set ordered by expiry; add, delete and check by a sequencer
// that scans the slot memory one entry per cycle through one compare unit.
// ----------------------------------------------------------------------------
//  channel   signals                                    transfer
//  input     start, busy, func, timer_id, elapse_ms,    start && !busy
//            now_us
//  result    done, kind, fired_id, status, wait_us,     done (one cycle)
//            last
//  config    cfg_we, cfg_wdata                          cfg_we
//
//  Add steps through multiply, add, slot scan and decide; an add that would
//  pass the water mark answers from idle with no scan. Delete: scan, decide.
//  Check: one scan per fired timer plus one, each followed by decide.
//  Every scan reads the slots through the single memory read port.
//  Reset clears all slots at once (valid flags). Results cannot be stalled.
// ----------------------------------------------------------------------------
module timer_expiry_queue #(
    parameter int MAX_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [7:0]  timer_id,
    input  logic [31:0] elapse_ms,
    input  logic [62:0] now_us,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output logic        done,
    output logic        kind,
    output logic [7:0]  fired_id,
    output logic [2:0]  status,
    output logic [31:0] wait_us,
    output logic        last
);
    import tmq_pkg::*;

    localparam int IW   = $clog2(MAX_TIMERS);
    localparam int CW   = $clog2(MAX_TIMERS + 1);
    localparam int CAPW = (CW > 5) ? CW : 5;
    localparam logic [IW:0]   N_SLOTS = (IW + 1)'(MAX_TIMERS);
    localparam logic [CAPW-1:0] N_CAP = CAPW'(MAX_TIMERS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_ADD    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  maxt_reg;
    logic [1:0]  func_reg;
    logic [7:0]  id_reg;
    logic [31:0] ms_reg;
    logic [62:0] now_reg;
    logic [41:0] prod_reg;
    logic [63:0] exp_reg;
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [CW-1:0] held_reg, held_next;

    logic [IW:0]   rd_idx_reg, rd_idx_next;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [63:0]   best_exp_reg, best_exp_next;
    logic [62:0]   best_beg_reg, best_beg_next;
    logic [7:0]    best_hdl_reg, best_hdl_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          dup_reg, dup_next;

    logic        done_next, kind_next, last_next;
    logic [7:0]  fired_next;
    logic [2:0]  status_next;
    logic [31:0] wait_next;

    slot_t mem_rd, mem_wd;
    logic  mem_we;
    logic  issue;
    logic  cand;
    logic [CAPW-1:0] cap;
    logic [CAPW:0]   held_plus;
    logic [63:0]     diff;

    tmq_slot_mem #(.DEPTH(MAX_TIMERS), .AW(IW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_idx_reg),
        .wdata (mem_wd),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (mem_rd)
    );

    assign busy = (state_reg != S_IDLE);
    assign mem_wd = '{handle: id_reg, t_begin: now_reg, t_expire: exp_reg};
    assign cap = (CAPW'(maxt_reg) < N_CAP) ? CAPW'(maxt_reg) : N_CAP;
    assign held_plus = (CAPW + 1)'(held_reg) + (CAPW + 1)'(1);
    assign issue = (rd_idx_reg < N_SLOTS);
    assign diff = best_exp_reg - {1'b0, now_reg};

    always_comb
    begin
        cand = cmp_vld_reg && valid_reg[cmp_idx_reg]
            && (func_reg != FN_DEL || mem_rd.handle == id_reg)
            && (!found_reg || fires_before(mem_rd.t_expire, mem_rd.t_begin,
                                           best_exp_reg, best_beg_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        held_next       = held_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = 1'b0;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_exp_next   = best_exp_reg;
        best_beg_next   = best_beg_reg;
        best_hdl_next   = best_hdl_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dup_next        = dup_reg;
        mem_we          = 1'b0;
        done_next       = 1'b0;
        kind_next       = 1'b1;
        fired_next      = 8'd0;
        status_next     = ST_OK;
        wait_next       = 32'd0;
        last_next       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rd_idx_next     = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    dup_next        = 1'b0;
                    case (func)
                        FN_ADD:
                        begin
                            if (held_plus > (CAPW + 1)'(cap))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                                state_next = S_MUL;
                        end
                        FN_DEL, FN_CHECK: state_next = S_SCAN;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL: state_next = S_ADD;
            S_ADD: state_next = S_SCAN;
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next  = rd_idx_reg + (IW + 1)'(1);
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (func_reg == FN_ADD)
                    begin
                        if (valid_reg[cmp_idx_reg])
                        begin
                            if (mem_rd.t_begin == now_reg && mem_rd.t_expire == exp_reg)
                                dup_next = 1'b1;
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (cand)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_exp_next = mem_rd.t_expire;
                        best_beg_next = mem_rd.t_begin;
                        best_hdl_next = mem_rd.handle;
                    end
                end
                if (!issue && !cmp_vld_reg)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (func_reg)
                    FN_ADD:
                    begin
                        if (dup_reg)
                            status_next = ST_DUP;
                        else if (!free_found_reg)
                            status_next = ST_FULL;
                        else
                        begin
                            mem_we                  = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            held_next               = held_reg + CW'(1);
                        end
                    end
                    FN_DEL:
                    begin
                        if (!found_reg)
                            status_next = ST_NOTFOUND;
                        else
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                            if (held_reg != '0)
                                held_next = held_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        if (!found_reg)
                            status_next = ST_EMPTY;
                        else if ({1'b0, now_reg} >= best_exp_reg)
                        begin
                            kind_next   = 1'b0;
                            fired_next  = best_hdl_reg;
                            last_next   = 1'b0;
                            valid_next[best_idx_reg] = 1'b0;
                            if (held_reg != '0)
                                held_next = held_reg - CW'(1);
                            rd_idx_next = '0;
                            found_next  = 1'b0;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            status_next = ST_PENDING;
                            wait_next   = (|diff[63:32]) ? 32'hFFFF_FFFF : diff[31:0];
                        end
                    end
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            maxt_reg    <= 5'd16;
            valid_reg   <= '0;
            held_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
                maxt_reg <= cfg_wdata;
            valid_reg   <= valid_next;
            held_reg    <= held_next;
            cmp_vld_reg <= cmp_vld_next;
            done        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg <= func;
            id_reg   <= timer_id;
            ms_reg   <= elapse_ms;
            now_reg  <= now_us;
        end
        prod_reg       <= 42'(ms_reg) * 42'(US_PER_MS);
        if (state_reg == S_ADD)
            exp_reg <= {1'b0, now_reg} + 64'(prod_reg);
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= rd_idx_reg[IW-1:0];
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_exp_reg   <= best_exp_next;
        best_beg_reg   <= best_beg_next;
        best_hdl_reg   <= best_hdl_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        dup_reg        <= dup_next;
        kind           <= kind_next;
        fired_id       <= fired_next;
        status         <= status_next;
        wait_us        <= wait_next;
        last           <= last_next;
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(held_reg))
        else $error("held count differs from valid slots");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !kind) |-> (!last && state_reg == S_SCAN))
        else $error("fired report must be followed by a rescan");

    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FN_NONE) |=> (!done && !busy))
        else $error("unused function produced activity");

endmodule

>>> sim/tb_timer_expiry_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_expiry_queue
// Self-checking bench for the timer queue. A predictor in the bench keeps its
// own copy of the timer slots and the water mark and works out the expected
// status and expiry reports for each accepted command. A monitor compares each
// strobed result with the oldest expectation. Directed tests come first, then
// random command streams with and without idle gaps.
// ----------------------------------------------------------------------------
module tb_timer_expiry_queue;
    import tmq_pkg::*;

    localparam int NSLOT   = 16;
    localparam int SETTLE  = 40;
    localparam int LIMIT   = 3000000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  fired_id;
        logic [2:0]  status;
        logic [31:0] wait_us;
        logic        last;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [7:0]  timer_id;
    logic [31:0] elapse_ms;
    logic [62:0] now_us;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        done;
    logic        kind;
    logic [7:0]  fired_id;
    logic [2:0]  status;
    logic [31:0] wait_us;
    logic        last;

    // predictor state
    logic        tm_valid [NSLOT];
    logic [7:0]  tm_handle[NSLOT];
    logic [63:0] tm_begin [NSLOT];
    logic [63:0] tm_expire[NSLOT];
    int          tm_count;
    int          water_mark;

    report_t     pending_reports[$];
    int          fail_count;
    int          cmd_count;
    int          report_count;
    int          fired_count;
    int          cycle_count;
    logic        gaps_on;
    logic [63:0] sim_now;

    timer_expiry_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .timer_id  (timer_id),
        .elapse_ms (elapse_ms),
        .now_us    (now_us),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .kind      (kind),
        .fired_id  (fired_id),
        .status    (status),
        .wait_us   (wait_us),
        .last      (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic report_t mk_report(logic k, logic [7:0] id, logic [2:0] st,
                                          logic [31:0] w, logic l);
        report_t r;
        r.kind = k;
        r.fired_id = id;
        r.status = st;
        r.wait_us = w;
        r.last = l;
        return r;
    endfunction

    function automatic logic earlier(int a, int b);
        logic r;
        if (tm_expire[a] != tm_expire[b])
            r = tm_expire[a] < tm_expire[b];
        else
            r = tm_begin[a] > tm_begin[b];
        return r;
    endfunction

    function automatic int next_to_fire(logic by_id, logic [7:0] id);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tm_valid[i] && (!by_id || tm_handle[i] == id))
                if (best < 0 || earlier(i, best))
                    best = i;
        return best;
    endfunction

    task automatic predict_queue(logic [1:0] fn, logic [7:0] id, logic [31:0] ms,
                                 logic [62:0] now);
        logic [63:0] t;
        logic [63:0] exp_t;
        logic [63:0] d;
        int          cap;
        int          free_i;
        int          s;
        logic        dup;
        t = {1'b0, now};
        cap = (water_mark < NSLOT) ? water_mark : NSLOT;
        case (fn)
            FN_ADD:
            begin
                exp_t = t + 64'(ms) * 64'(US_PER_MS);
                free_i = -1;
                dup = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                    if (tm_valid[i])
                    begin
                        if (tm_begin[i] == t && tm_expire[i] == exp_t)
                            dup = 1'b1;
                    end
                    else if (free_i < 0)
                        free_i = i;
                if (tm_count + 1 > cap)
                    pending_reports.push_back(mk_report(1'b1, 8'd0, ST_FULL, 32'd0, 1'b1));
                else if (dup)
                    pending_reports.push_back(mk_report(1'b1, 8'd0, ST_DUP, 32'd0, 1'b1));
                else if (free_i < 0)
                    pending_reports.push_back(mk_report(1'b1, 8'd0, ST_FULL, 32'd0, 1'b1));
                else
                begin
                    tm_valid[free_i] = 1'b1;
                    tm_handle[free_i] = id;
                    tm_begin[free_i] = t;
                    tm_expire[free_i] = exp_t;
                    tm_count++;
                    pending_reports.push_back(mk_report(1'b1, 8'd0, ST_OK, 32'd0, 1'b1));
                end
            end
            FN_DEL:
            begin
                s = next_to_fire(1'b1, id);
                if (s < 0)
                    pending_reports.push_back(
                        mk_report(1'b1, 8'd0, ST_NOTFOUND, 32'd0, 1'b1));
                else
                begin
                    tm_valid[s] = 1'b0;
                    if (tm_count > 0)
                        tm_count--;
                    pending_reports.push_back(mk_report(1'b1, 8'd0, ST_OK, 32'd0, 1'b1));
                end
            end
            FN_CHECK:
            begin
                forever
                begin
                    s = next_to_fire(1'b0, 8'd0);
                    if (s < 0)
                    begin
                        pending_reports.push_back(
                            mk_report(1'b1, 8'd0, ST_EMPTY, 32'd0, 1'b1));
                        break;
                    end
                    if (t >= tm_expire[s])
                    begin
                        pending_reports.push_back(
                            mk_report(1'b0, tm_handle[s], ST_OK, 32'd0, 1'b0));
                        tm_valid[s] = 1'b0;
                        if (tm_count > 0)
                            tm_count--;
                        fired_count++;
                    end
                    else
                    begin
                        d = tm_expire[s] - t;
                        if (d > 64'hFFFF_FFFF)
                            d = 64'hFFFF_FFFF;
                        pending_reports.push_back(
                            mk_report(1'b1, 8'd0, ST_PENDING, d[31:0], 1'b1));
                        break;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // result monitor
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n && done)
        begin
            report_count++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result kind=%0d status=%0d", kind, status);
                fail_count++;
            end
            else
            begin
                e = pending_reports.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, kind);
                    fail_count++;
                end
                if (fired_id !== e.fired_id)
                begin
                    $error("fired_id: expected %0d, got %0d", e.fired_id, fired_id);
                    fail_count++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    fail_count++;
                end
                if (wait_us !== e.wait_us)
                begin
                    $error("wait_us: expected %0d, got %0d", e.wait_us, wait_us);
                    fail_count++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_cmd(logic [1:0] fn, logic [7:0] id, logic [31:0] ms,
                            logic [62:0] now);
        if (gaps_on && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1'b1;
        func <= fn;
        timer_id <= id;
        elapse_ms <= ms;
        now_us <= now;
        do
            @(posedge clk);
        while (busy);
        cmd_count++;
        predict_queue(fn, id, ms, now);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_water_mark(logic [4:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        water_mark = v;
    endtask

    task automatic test_empty_set();
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd0);
        send_cmd(FN_DEL, 8'd0, 32'd0, 63'd0);
        send_cmd(FN_DEL, 8'hFF, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_add_dup_expire();
        send_cmd(FN_ADD, 8'd1, 32'd2, 63'd100);
        send_cmd(FN_ADD, 8'd2, 32'd2, 63'd100);
        send_cmd(FN_ADD, 8'd3, 32'd1, 63'd1100);
        send_cmd(FN_ADD, 8'd4, 32'd0, 63'd100);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd150);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd2100);
    endtask

    task automatic test_repeated_handle();
        send_cmd(FN_ADD, 8'd7, 32'd5, 63'd3000);
        send_cmd(FN_ADD, 8'd7, 32'd3, 63'd3000);
        send_cmd(FN_DEL, 8'd7, 32'd0, 63'd0);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd3000);
        send_cmd(FN_DEL, 8'd7, 32'd0, 63'd0);
    endtask

    task automatic test_extremes();
        send_cmd(FN_ADD, 8'hFF, 32'hFFFF_FFFF, '1);
        send_cmd(FN_ADD, 8'hAA, 32'hFFFF_FFFF, 63'd0);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd5);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'h7FFF_FFFF_0000_0000);
        send_cmd(FN_CHECK, 8'd0, 32'd0, '1);
        send_cmd(FN_NONE, 8'h55, 32'h1234_5678, 63'd9);
        send_cmd(FN_CHECK, 8'hFF, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_water_mark();
        set_water_mark(5'd0);
        send_cmd(FN_ADD, 8'd1, 32'd1, 63'd10);
        set_water_mark(5'd31);
        for (int i = 0; i < 17; i++)
            send_cmd(FN_ADD, 8'(i), 32'(i), 63'd20);
        set_water_mark(5'd2);
        send_cmd(FN_ADD, 8'd9, 32'd1, 63'd30);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd100_000);
        set_water_mark(5'd1);
        send_cmd(FN_ADD, 8'd9, 32'd1, 63'd30);
        send_cmd(FN_ADD, 8'd8, 32'd1, 63'd40);
        send_cmd(FN_CHECK, 8'd0, 32'd0, 63'd200_000);
    endtask

    task automatic test_random(int n, logic gaps);
        int          r;
        logic [1:0]  fn;
        logic [7:0]  id;
        logic [31:0] ms;
        logic [62:0] now;
        logic [31:0] last_ms;
        logic [62:0] last_now;
        gaps_on = gaps;
        last_ms = '0;
        last_now = '0;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            sim_now += $urandom_range(3000);
            now = sim_now[62:0];
            id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            ms = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(6));
            if ($urandom_range(39) == 0)
                now = 63'({$urandom, $urandom});
            if (r < 45)
            begin
                fn = FN_ADD;
                if ($urandom_range(7) == 0)
                begin
                    ms = last_ms;
                    now = last_now;
                end
                last_ms = ms;
                last_now = now;
            end
            else if (r < 65)
                fn = FN_DEL;
            else if (r < 96)
                fn = FN_CHECK;
            else
                fn = FN_NONE;
            send_cmd(fn, id, ms, now);
        end
        gaps_on = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FN_ADD;
        timer_id = '0;
        elapse_ms = '0;
        now_us = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        cmd_count = 0;
        report_count = 0;
        fired_count = 0;
        cycle_count = 0;
        gaps_on = 1'b0;
        sim_now = 64'd1_000_000;
        tm_count = 0;
        water_mark = 16;
        for (int i = 0; i < NSLOT; i++)
        begin
            tm_valid[i] = 1'b0;
            tm_handle[i] = '0;
            tm_begin[i] = '0;
            tm_expire[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_add_dup_expire();
        test_repeated_handle();
        test_extremes();
        test_water_mark();
        set_water_mark(5'd16);
        test_random(130, 1'b1);
        test_random(90, 1'b0);
        set_water_mark(5'd5);
        test_random(70, 1'b1);
        set_water_mark(5'd31);
        test_random(85, 1'b1);
        send_cmd(FN_CHECK, 8'd0, 32'd0, '1);

        wait_idle();
        $display("Covered %0d commands, %0d results, %0d expiry reports.",
                 cmd_count, report_count, fired_count);
        $display("Water marks 0, 1, 2, 5, 16 and 31 exercised; %0d mismatches.",
                 fail_count);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/tmq_pkg.sv
sv/tmq_slot_mem.sv
sv/timer_expiry_queue.sv
sim/tb_timer_expiry_queue.sv
